/* rtl/core/qxmm_pkg.sv */
`timescale 1ns / 1ps

package qxmm_pkg;

    // Q2.14 fixed point, 16384 = 1.0
    localparam int FRACTION_BITS = 14;
    localparam int NUM_MOTORS    = 4;

    localparam int CMD_W   = 16;
    localparam int GAIN_W  = 15;
    localparam int LEVEL_W = 15;
    localparam int STAMP_W = 64;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // product of two CMD_W signed operands
    localparam int PROD_W  = 2 * CMD_W;
    // sum of three products
    localparam int ACC_W   = PROD_W + 2;
    // accumulator after the fraction shift
    localparam int TERM_W  = ACC_W - FRACTION_BITS;
    // throttle plus term, with room for the carry
    localparam int LVL_W   = TERM_W + 1;

    localparam logic [LEVEL_W-1:0] ONE_Q = LEVEL_W'(1 << FRACTION_BITS);

    // register index on paddr[3:2]
    typedef enum logic [1:0] {
        REG_ROLL_GAIN   = 2'd0,
        REG_PITCH_GAIN  = 2'd1,
        REG_YAW_GAIN    = 2'd2,
        REG_YAW_FLIP    = 2'd3
    } t_reg_idx;

    // motor sign masks: bit m set means the term is subtracted for motor m
    localparam logic [NUM_MOTORS-1:0] NEG_ROLL  = 4'b1100;
    localparam logic [NUM_MOTORS-1:0] NEG_PITCH = 4'b0101;
    localparam logic [NUM_MOTORS-1:0] NEG_YAW   = 4'b0110;

    typedef logic signed [ACC_W-1:0]   t_acc;
    typedef logic signed [TERM_W-1:0]  t_term;
    typedef logic [LEVEL_W-1:0]        t_level;

endpackage

/* rtl/core/quad_x_motor_mixer_unit.sv */
`timescale 1ns / 1ps

// X-quad motor mixer. One setpoint is taken per cycle (busy stays low) and
// its result appears on the o_ result ports after four register stages, for
// exactly one cycle with o_valid high; there is no backpressure, so the
// receiver must capture every result as it goes by. The stages are range
// check, gain multiply, signed term sum with fraction shift, and throttle add
// with clamp. The user writes gains and the props-out flag over the APB port
// only while no item is in flight; the block itself does not enforce this.
module quad_x_motor_mixer_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    input  logic                           start,
    output logic                           busy,
    input  logic                           i_setpoint_valid,
    input  logic signed [qxmm_pkg::CMD_W-1:0]   i_roll_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0]   i_pitch_cmd,
    input  logic signed [qxmm_pkg::CMD_W-1:0]   i_yaw_cmd,
    input  logic [qxmm_pkg::GAIN_W-1:0]    i_throttle_cmd,
    input  logic [qxmm_pkg::STAMP_W-1:0]   i_stamp_in,

    output logic                           o_valid,
    output logic                           o_mix_ok,
    output logic [qxmm_pkg::LEVEL_W-1:0]   o_motor_zero_level,
    output logic [qxmm_pkg::LEVEL_W-1:0]   o_motor_one_level,
    output logic [qxmm_pkg::LEVEL_W-1:0]   o_motor_two_level,
    output logic [qxmm_pkg::LEVEL_W-1:0]   o_motor_three_level,
    output logic [qxmm_pkg::STAMP_W-1:0]   o_stamp_out,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [qxmm_pkg::ADDR_W-1:0]    paddr,
    input  logic [qxmm_pkg::DATA_W-1:0]    pwdata,
    output logic [qxmm_pkg::DATA_W-1:0]    prdata,
    output logic                           pready
);
    import qxmm_pkg::*;

    // configuration
    logic [GAIN_W-1:0] r_roll_gain;
    logic [GAIN_W-1:0] r_pitch_gain;
    logic [GAIN_W-1:0] r_yaw_gain;
    logic              r_yaw_flip;

    logic     cfg_wr;
    t_reg_idx cfg_idx;

    assign pready  = 1'b1;
    assign busy    = 1'b0;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_roll_gain  <= '0;
            r_pitch_gain <= '0;
            r_yaw_gain   <= '0;
            r_yaw_flip   <= 1'b0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_ROLL_GAIN:  r_roll_gain  <= pwdata[GAIN_W-1:0];
                REG_PITCH_GAIN: r_pitch_gain <= pwdata[GAIN_W-1:0];
                REG_YAW_GAIN:   r_yaw_gain   <= pwdata[GAIN_W-1:0];
                REG_YAW_FLIP:   r_yaw_flip   <= pwdata[0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_ROLL_GAIN:  prdata = DATA_W'(r_roll_gain);
            REG_PITCH_GAIN: prdata = DATA_W'(r_pitch_gain);
            REG_YAW_GAIN:   prdata = DATA_W'(r_yaw_gain);
            REG_YAW_FLIP:   prdata = DATA_W'(r_yaw_flip);
            default:        prdata = '0;
        endcase
    end

    // stage 1: range check, capture operands
    localparam logic signed [CMD_W-1:0] CMD_MAX = CMD_W'(signed'({1'b0, ONE_Q}));
    localparam logic signed [CMD_W-1:0] CMD_MIN = -CMD_MAX;

    logic in_acc;
    logic n_ok;
    logic signed [CMD_W-1:0] n_gy;

    assign in_acc = start && !busy;

    always_comb begin
        n_ok = (r_roll_gain <= ONE_Q) && (r_pitch_gain <= ONE_Q) &&
               (r_yaw_gain <= ONE_Q) && i_setpoint_valid &&
               (i_roll_cmd  >= CMD_MIN) && (i_roll_cmd  <= CMD_MAX) &&
               (i_pitch_cmd >= CMD_MIN) && (i_pitch_cmd <= CMD_MAX) &&
               (i_yaw_cmd   >= CMD_MIN) && (i_yaw_cmd   <= CMD_MAX) &&
               (i_throttle_cmd <= ONE_Q);
        // props out flips every yaw term
        n_gy = r_yaw_flip ? -signed'({1'b0, r_yaw_gain}) : signed'({1'b0, r_yaw_gain});
    end

    logic                    r_v1;
    logic                    r_s1_ok;
    logic                    r_s1_run;
    logic signed [CMD_W-1:0] r_s1_roll, r_s1_pitch, r_s1_yaw;
    logic signed [CMD_W-1:0] r_s1_gr, r_s1_gp, r_s1_gy;
    logic [GAIN_W-1:0]       r_s1_thr;
    logic [STAMP_W-1:0]      r_s1_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_ok    <= n_ok;
        r_s1_run   <= n_ok && (i_throttle_cmd != '0);
        r_s1_roll  <= i_roll_cmd;
        r_s1_pitch <= i_pitch_cmd;
        r_s1_yaw   <= i_yaw_cmd;
        r_s1_gr    <= signed'({1'b0, r_roll_gain});
        r_s1_gp    <= signed'({1'b0, r_pitch_gain});
        r_s1_gy    <= n_gy;
        r_s1_thr   <= i_throttle_cmd;
        r_s1_stamp <= i_stamp_in;
    end

    // stage 2: weight each axis
    logic                     r_v2;
    logic                     r_s2_ok;
    logic                     r_s2_run;
    logic signed [PROD_W-1:0] r_s2_pr, r_s2_pp, r_s2_py;
    logic [GAIN_W-1:0]        r_s2_thr;
    logic [STAMP_W-1:0]       r_s2_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_ok    <= r_s1_ok;
        r_s2_run   <= r_s1_run;
        r_s2_pr    <= r_s1_roll  * r_s1_gr;
        r_s2_pp    <= r_s1_pitch * r_s1_gp;
        r_s2_py    <= r_s1_yaw   * r_s1_gy;
        r_s2_thr   <= r_s1_thr;
        r_s2_stamp <= r_s1_stamp;
    end

    // stage 3: signed sum per motor, floor shift
    t_acc  pr_x, pp_x, py_x;
    t_acc  acc [NUM_MOTORS];
    t_term n_term [NUM_MOTORS];

    always_comb begin
        pr_x = ACC_W'(r_s2_pr);
        pp_x = ACC_W'(r_s2_pp);
        py_x = ACC_W'(r_s2_py);
        for (int m = 0; m < NUM_MOTORS; m++) begin
            acc[m] = (NEG_ROLL[m]  ? -pr_x : pr_x) +
                     (NEG_PITCH[m] ? -pp_x : pp_x) +
                     (NEG_YAW[m]   ? -py_x : py_x);
            n_term[m] = TERM_W'(acc[m] >>> FRACTION_BITS);
        end
    end

    logic               r_v3;
    logic               r_s3_ok;
    logic               r_s3_run;
    t_term              r_s3_term [NUM_MOTORS];
    logic [GAIN_W-1:0]  r_s3_thr;
    logic [STAMP_W-1:0] r_s3_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v3 <= 1'b0;
        end else begin
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_ok    <= r_s2_ok;
        r_s3_run   <= r_s2_run;
        r_s3_term  <= n_term;
        r_s3_thr   <= r_s2_thr;
        r_s3_stamp <= r_s2_stamp;
    end

    // stage 4: add throttle, clamp to [0, 1.0]; zero if the check failed or throttle is zero
    logic signed [LVL_W-1:0] lvl [NUM_MOTORS];
    t_level                  n_level [NUM_MOTORS];

    always_comb begin
        for (int m = 0; m < NUM_MOTORS; m++) begin
            lvl[m] = signed'(LVL_W'(r_s3_thr)) + LVL_W'(r_s3_term[m]);
            if (!r_s3_run || lvl[m] < 0) begin
                n_level[m] = '0;
            end else if (lvl[m] > signed'(LVL_W'(ONE_Q))) begin
                n_level[m] = ONE_Q;
            end else begin
                n_level[m] = lvl[m][LEVEL_W-1:0];
            end
        end
    end

    logic               r_o_valid;
    logic               r_o_ok;
    t_level             r_o_level [NUM_MOTORS];
    logic [STAMP_W-1:0] r_o_stamp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else begin
            r_o_valid <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_ok    <= r_s3_ok;
        r_o_level <= n_level;
        r_o_stamp <= r_s3_ok ? r_s3_stamp : '0;
    end

    assign o_valid             = r_o_valid;
    assign o_mix_ok            = r_o_ok;
    assign o_motor_zero_level  = r_o_level[0];
    assign o_motor_one_level   = r_o_level[1];
    assign o_motor_two_level   = r_o_level[2];
    assign o_motor_three_level = r_o_level[3];
    assign o_stamp_out         = r_o_stamp;

endmodule
